FILE: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked out of reset
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/vsaa_pkg.sv
package vsaa_pkg;

  localparam int TONE_HALF_PERIOD  = 10;
  localparam int PRESS_BLINK_TICKS = 5;
  localparam int TEMP_BLINK_TICKS  = 10;
  localparam int PULSE_BLINK_TICKS = 20;

  localparam int TONE_CW  = (TONE_HALF_PERIOD > 1) ? $clog2(TONE_HALF_PERIOD) : 1;
  localparam int PRESS_CW = (PRESS_BLINK_TICKS > 1) ? $clog2(PRESS_BLINK_TICKS) : 1;
  localparam int TEMP_CW  = (TEMP_BLINK_TICKS > 1) ? $clog2(TEMP_BLINK_TICKS) : 1;
  localparam int PULSE_CW = (PULSE_BLINK_TICKS > 1) ? $clog2(PULSE_BLINK_TICKS) : 1;

  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  typedef logic [2:0] reg_idx_t;
  localparam reg_idx_t REG_SYS_LIMIT   = 3'd0;
  localparam reg_idx_t REG_DIA_LIMIT   = 3'd1;
  localparam reg_idx_t REG_TEMP_LOW    = 3'd2;
  localparam reg_idx_t REG_TEMP_HIGH   = 3'd3;
  localparam reg_idx_t REG_PULSE_LOW   = 3'd4;
  localparam reg_idx_t REG_PULSE_HIGH  = 3'd5;
  localparam reg_idx_t REG_BATT_MIN    = 3'd6;
  localparam reg_idx_t REG_SNOOZE      = 3'd7;

  localparam logic [11:0] SYS_LIMIT_RST   = 12'd2304;
  localparam logic [11:0] DIA_LIMIT_RST   = 12'd1536;
  localparam logic [11:0] TEMP_LOW_RST    = 12'd549;
  localparam logic [11:0] TEMP_HIGH_RST   = 12'd635;
  localparam logic [11:0] PULSE_LOW_RST   = 12'd912;
  localparam logic [11:0] PULSE_HIGH_RST  = 12'd1680;
  localparam logic [9:0]  BATT_MIN_RST    = 10'd40;
  localparam logic [15:0] SNOOZE_RST      = 16'd25;

  typedef enum logic [1:0] {
    ALARM_OFF    = 2'd0,
    ALARM_ON     = 2'd1,
    ALARM_ASLEEP = 2'd2
  } alarm_t;

  typedef enum logic [1:0] {
    KIND_NONE        = 2'd0,
    KIND_PRESSURE    = 2'd1,
    KIND_TEMPERATURE = 2'd2,
    KIND_PULSE       = 2'd3
  } warn_t;

  typedef struct packed {
    logic [11:0] temperature;
    logic [11:0] systolic;
    logic [11:0] diastolic;
    logic [11:0] pulse_rate;
    logic [9:0]  battery_level;
    logic        ack_pressed;
  } in_item_t;

  typedef struct packed {
    logic       tone_on;
    logic       red_led;
    logic       green_led;
    logic       yellow_led;
    logic       remote_active;
    logic [1:0] alarm_mode;
    logic [1:0] warning_kind;
  } out_item_t;

endpackage

FILE: rtl/vsaa_if.sv
interface vsaa_in_if;
  import vsaa_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface vsaa_out_if;
  import vsaa_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/vital_sign_alarm_annunciator_core.sv
// Vital-sign alarm annunciator. Each request is one scheduler tick; the block
// takes one request per clock unless the output stalls, and returns exactly
// one result per request, through one input register and one result register.
// The input stage keeps taking requests while a result waits, as long as
// the result register drains. Blink and tone rates use small modulo phase
// counters that step with each tick, and the 32-bit tick count drives the
// snooze wake-up. Limits are written through the APB port, by the user only
// while idle; the block does not enforce it. No clearing pass follows reset.
`include "assert_macros.svh"

module vital_sign_alarm_annunciator_core (
  input  logic                          clk,
  input  logic                          rst_n,
  vsaa_in_if.sink                       in_ch,
  vsaa_out_if.source                    out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [vsaa_pkg::CFG_AW-1:0]   paddr,
  input  logic [vsaa_pkg::CFG_DW-1:0]   pwdata,
  output logic [vsaa_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready
);
  import vsaa_pkg::*;

  // configuration
  logic [11:0] sys_lim_r, dia_lim_r, temp_lo_r, temp_hi_r, pulse_lo_r, pulse_hi_r;
  logic [9:0]  batt_min_r;
  logic [15:0] snooze_r;
  logic        cfg_wr;
  reg_idx_t    cfg_idx;

  // pipeline
  logic      s1_valid_r;
  in_item_t  s1_data_r;
  logic      in_acc;
  logic      s1_adv;
  logic      out_valid_r;
  out_item_t out_data_r;
  out_item_t out_data_nxt;

  // tick state
  alarm_t              alarm_r, alarm_nxt, alarm_mid;
  warn_t               warn_r, warn_nxt;
  logic                batt_r, batt_nxt;
  logic                tone_phase_r, tone_phase_nxt;
  logic                tone_act_r, tone_act_nxt;
  logic                red_r, red_nxt;
  logic [31:0]         tick_r, wake_r, wake_nxt;
  logic [TONE_CW-1:0]  tone_ph_r, tone_ph_nxt;
  logic [PRESS_CW-1:0] press_ph_r, press_ph_nxt;
  logic [TEMP_CW-1:0]  temp_ph_r, temp_ph_nxt;
  logic [PULSE_CW-1:0] pulse_ph_r, pulse_ph_nxt;
  logic                tick_wrap;
  logic                sys_hi;
  logic                blink_hit;
  logic                remote;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = paddr[CFG_AW-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sys_lim_r  <= SYS_LIMIT_RST;
      dia_lim_r  <= DIA_LIMIT_RST;
      temp_lo_r  <= TEMP_LOW_RST;
      temp_hi_r  <= TEMP_HIGH_RST;
      pulse_lo_r <= PULSE_LOW_RST;
      pulse_hi_r <= PULSE_HIGH_RST;
      batt_min_r <= BATT_MIN_RST;
      snooze_r   <= SNOOZE_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_SYS_LIMIT:  sys_lim_r  <= pwdata[11:0];
        REG_DIA_LIMIT:  dia_lim_r  <= pwdata[11:0];
        REG_TEMP_LOW:   temp_lo_r  <= pwdata[11:0];
        REG_TEMP_HIGH:  temp_hi_r  <= pwdata[11:0];
        REG_PULSE_LOW:  pulse_lo_r <= pwdata[11:0];
        REG_PULSE_HIGH: pulse_hi_r <= pwdata[11:0];
        REG_BATT_MIN:   batt_min_r <= pwdata[9:0];
        REG_SNOOZE:     snooze_r   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_SYS_LIMIT:  prdata = {20'd0, sys_lim_r};
      REG_DIA_LIMIT:  prdata = {20'd0, dia_lim_r};
      REG_TEMP_LOW:   prdata = {20'd0, temp_lo_r};
      REG_TEMP_HIGH:  prdata = {20'd0, temp_hi_r};
      REG_PULSE_LOW:  prdata = {20'd0, pulse_lo_r};
      REG_PULSE_HIGH: prdata = {20'd0, pulse_hi_r};
      REG_BATT_MIN:   prdata = {22'd0, batt_min_r};
      REG_SNOOZE:     prdata = {16'd0, snooze_r};
      default:        prdata = '0;
    endcase
  end

  // handshake
  assign s1_adv       = s1_valid_r & (~out_valid_r | out_ch.ready);
  assign in_ch.ready  = ~s1_valid_r | s1_adv;
  assign in_acc       = in_ch.valid & in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // per-tick logic
  always_comb begin
    sys_hi = s1_data_r.systolic > sys_lim_r;

    if (sys_hi) begin
      alarm_mid = (alarm_r == ALARM_OFF) ? ALARM_ON : alarm_r;
    end else begin
      alarm_mid = ALARM_OFF;
    end

    if (sys_hi || (s1_data_r.diastolic > dia_lim_r)) begin
      warn_nxt = KIND_PRESSURE;
    end else if ((s1_data_r.temperature < temp_lo_r) ||
                 (s1_data_r.temperature > temp_hi_r)) begin
      warn_nxt = KIND_TEMPERATURE;
    end else if ((s1_data_r.pulse_rate < pulse_lo_r) ||
                 (s1_data_r.pulse_rate > pulse_hi_r)) begin
      warn_nxt = KIND_PULSE;
    end else begin
      warn_nxt = KIND_NONE;
    end

    batt_nxt = batt_r | (s1_data_r.battery_level < batt_min_r);

    tone_act_nxt   = tone_act_r;
    tone_phase_nxt = tone_phase_r;
    if (alarm_mid == ALARM_ON) begin
      if (tone_ph_r == '0) begin
        tone_act_nxt   = tone_phase_r;
        tone_phase_nxt = ~tone_phase_r;
      end
    end else begin
      tone_act_nxt = 1'b0;
    end

    unique case (warn_nxt)
      KIND_PRESSURE:    blink_hit = (press_ph_r == '0);
      KIND_TEMPERATURE: blink_hit = (temp_ph_r == '0);
      default:          blink_hit = (pulse_ph_r == '0);
    endcase

    if (warn_nxt == KIND_NONE) begin
      red_nxt = 1'b0;
    end else if (warn_nxt != warn_r) begin
      red_nxt = 1'b1;
    end else if (blink_hit) begin
      red_nxt = ~red_r;
    end else begin
      red_nxt = red_r;
    end

    remote = (warn_nxt != KIND_NONE) || (alarm_mid != ALARM_OFF);

    alarm_nxt = alarm_mid;
    wake_nxt  = wake_r;
    if (s1_data_r.ack_pressed && (alarm_mid == ALARM_ON)) begin
      alarm_nxt = ALARM_ASLEEP;
      wake_nxt  = tick_r + {16'd0, snooze_r};
    end
    if ((tick_r == wake_nxt) && (alarm_nxt == ALARM_ASLEEP)) begin
      alarm_nxt = ALARM_ON;
    end

    // phases restart with the tick count when it wraps
    tick_wrap    = &tick_r;
    tone_ph_nxt  = (tick_wrap || (tone_ph_r == TONE_CW'(TONE_HALF_PERIOD - 1))) ?
                   '0 : tone_ph_r + 1'b1;
    press_ph_nxt = (tick_wrap || (press_ph_r == PRESS_CW'(PRESS_BLINK_TICKS - 1))) ?
                   '0 : press_ph_r + 1'b1;
    temp_ph_nxt  = (tick_wrap || (temp_ph_r == TEMP_CW'(TEMP_BLINK_TICKS - 1))) ?
                   '0 : temp_ph_r + 1'b1;
    pulse_ph_nxt = (tick_wrap || (pulse_ph_r == PULSE_CW'(PULSE_BLINK_TICKS - 1))) ?
                   '0 : pulse_ph_r + 1'b1;

    out_data_nxt.tone_on       = tone_act_nxt;
    out_data_nxt.red_led       = red_nxt;
    out_data_nxt.green_led     = (warn_nxt == KIND_NONE) & ~batt_nxt;
    out_data_nxt.yellow_led    = batt_nxt;
    out_data_nxt.remote_active = remote;
    out_data_nxt.alarm_mode    = alarm_nxt;
    out_data_nxt.warning_kind  = warn_nxt;
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_data_r <= in_ch.data;
    end
    if (s1_adv) begin
      out_data_r <= out_data_nxt;
      wake_r     <= wake_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      alarm_r      <= ALARM_OFF;
      warn_r       <= KIND_NONE;
      batt_r       <= 1'b0;
      tone_phase_r <= 1'b0;
      tone_act_r   <= 1'b0;
      red_r        <= 1'b0;
      tick_r       <= '0;
      tone_ph_r    <= '0;
      press_ph_r   <= '0;
      temp_ph_r    <= '0;
      pulse_ph_r   <= '0;
    end else begin
      s1_valid_r  <= in_acc | (s1_valid_r & ~s1_adv);
      out_valid_r <= s1_adv | (out_valid_r & ~out_ch.ready);
      if (s1_adv) begin
        alarm_r      <= alarm_nxt;
        warn_r       <= warn_nxt;
        batt_r       <= batt_nxt;
        tone_phase_r <= tone_phase_nxt;
        tone_act_r   <= tone_act_nxt;
        red_r        <= red_nxt;
        tick_r       <= tick_r + 32'd1;
        tone_ph_r    <= tone_ph_nxt;
        press_ph_r   <= press_ph_nxt;
        temp_ph_r    <= temp_ph_nxt;
        pulse_ph_r   <= pulse_ph_nxt;
      end
    end
  end

  // wake_r has no reset; it is written before any asleep state can use it
  `ASSERT_NXT(a_batt_sticky, clk, rst_n, batt_r, batt_r)
  `ASSERT_IMP(a_red_needs_warn, clk, rst_n, red_r, warn_r != KIND_NONE)
  `ASSERT_IMP(a_tone_ph_range, clk, rst_n, 1'b1, tone_ph_r <= TONE_CW'(TONE_HALF_PERIOD - 1))

endmodule

FILE: tb/tb.sv
module tb;
  import vsaa_pkg::*;

  localparam int QUIET_LIMIT = 2000;

  typedef struct {
    bit sys_hi;
    bit dia_hi;
    bit temp_out;
    bit pulse_out;
    bit batt_dip;
    int ack_pct;
    int len;
  } episode_t;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic pready;

  vsaa_in_if in_ch ();
  vsaa_out_if out_ch ();

  vital_sign_alarm_annunciator_core u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // limits as programmed, indexed by register
  logic [15:0] lim_val [8];

  // annunciator state mirror
  alarm_t      alarm_st;
  warn_t       warn_st;
  logic        batt_low_st;
  logic        tone_phase_st;
  logic        tone_st;
  logic        red_st;
  logic [31:0] tick_cnt;
  logic [31:0] wake_at;

  in_item_t  pending_ticks [$];
  out_item_t expected_lamps [$];

  int  fail_count;
  int  quiet_cycles;
  int  idle_pct;
  int  gap_left;
  int  stall_left;
  bit  in_taken;
  bit  hold_send;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [15:0] reg_bits(reg_idx_t idx);
    case (idx)
      REG_BATT_MIN: return 16'h03FF;
      REG_SNOOZE:   return 16'hFFFF;
      default:      return 16'h0FFF;
    endcase
  endfunction

  function automatic out_item_t annunciate(in_item_t t);
    out_item_t r;
    warn_t prev_w;
    logic remote;
    int unsigned blink;
    prev_w = warn_st;

    if (t.systolic > lim_val[REG_SYS_LIMIT][11:0]) begin
      if (alarm_st == ALARM_OFF) alarm_st = ALARM_ON;
    end else begin
      alarm_st = ALARM_OFF;
    end

    if (t.systolic > lim_val[REG_SYS_LIMIT][11:0] ||
        t.diastolic > lim_val[REG_DIA_LIMIT][11:0])
      warn_st = KIND_PRESSURE;
    else if (t.temperature < lim_val[REG_TEMP_LOW][11:0] ||
             t.temperature > lim_val[REG_TEMP_HIGH][11:0])
      warn_st = KIND_TEMPERATURE;
    else if (t.pulse_rate < lim_val[REG_PULSE_LOW][11:0] ||
             t.pulse_rate > lim_val[REG_PULSE_HIGH][11:0])
      warn_st = KIND_PULSE;
    else
      warn_st = KIND_NONE;

    if (t.battery_level < lim_val[REG_BATT_MIN][9:0]) batt_low_st = 1'b1;

    if (alarm_st == ALARM_ON) begin
      if (tick_cnt % TONE_HALF_PERIOD == 0) begin
        tone_st = tone_phase_st;
        tone_phase_st = !tone_phase_st;
      end
    end else begin
      tone_st = 1'b0;
    end

    case (warn_st)
      KIND_PRESSURE:    blink = PRESS_BLINK_TICKS;
      KIND_TEMPERATURE: blink = TEMP_BLINK_TICKS;
      default:          blink = PULSE_BLINK_TICKS;
    endcase
    if (warn_st == KIND_NONE) red_st = 1'b0;
    else if (warn_st != prev_w) red_st = 1'b1;
    else if (tick_cnt % blink == 0) red_st = !red_st;

    remote = (warn_st != KIND_NONE) || (alarm_st != ALARM_OFF);

    if (t.ack_pressed && alarm_st == ALARM_ON) begin
      alarm_st = ALARM_ASLEEP;
      wake_at = tick_cnt + {16'd0, lim_val[REG_SNOOZE]};
    end
    if (tick_cnt == wake_at && alarm_st == ALARM_ASLEEP) alarm_st = ALARM_ON;

    r.tone_on       = tone_st;
    r.red_led       = red_st;
    r.green_led     = (warn_st == KIND_NONE) && !batt_low_st;
    r.yellow_led    = batt_low_st;
    r.remote_active = remote;
    r.alarm_mode    = alarm_st;
    r.warning_kind  = warn_st;
    tick_cnt = tick_cnt + 32'd1;
    return r;
  endfunction

  function automatic logic [11:0] above(logic [11:0] lim);
    if (lim == 12'hFFF) return lim;
    if ($urandom_range(0, 5) == 0) return lim + 12'd1;
    return 12'($urandom_range(4095, lim + 1));
  endfunction

  function automatic logic [11:0] at_most(logic [11:0] lim);
    if ($urandom_range(0, 5) == 0) return lim;
    return 12'($urandom_range(lim, 0));
  endfunction

  function automatic logic [11:0] in_band(logic [11:0] lo, logic [11:0] hi);
    if (lo > hi) return 12'($urandom_range(4095, 0));
    return 12'($urandom_range(hi, lo));
  endfunction

  function automatic logic [11:0] out_band(logic [11:0] lo, logic [11:0] hi);
    if (lo > 0 && (hi == 12'hFFF || $urandom_range(0, 1) == 1))
      return 12'($urandom_range(lo - 1, 0));
    if (hi != 12'hFFF) return above(hi);
    return 12'($urandom_range(4095, 0));
  endfunction

  function automatic in_item_t make_tick(episode_t ep);
    in_item_t t;
    logic [63:0] noise;
    logic [9:0] bmin;
    if ($urandom_range(0, 19) == 0) begin
      noise = {$urandom, $urandom};
      t = noise[$bits(in_item_t)-1:0];
      return t;
    end
    bmin = lim_val[REG_BATT_MIN][9:0];
    t.systolic  = ep.sys_hi ? above(lim_val[REG_SYS_LIMIT][11:0])
                            : at_most(lim_val[REG_SYS_LIMIT][11:0]);
    t.diastolic = ep.dia_hi ? above(lim_val[REG_DIA_LIMIT][11:0])
                            : at_most(lim_val[REG_DIA_LIMIT][11:0]);
    t.temperature = ep.temp_out
        ? out_band(lim_val[REG_TEMP_LOW][11:0], lim_val[REG_TEMP_HIGH][11:0])
        : in_band(lim_val[REG_TEMP_LOW][11:0], lim_val[REG_TEMP_HIGH][11:0]);
    t.pulse_rate = ep.pulse_out
        ? out_band(lim_val[REG_PULSE_LOW][11:0], lim_val[REG_PULSE_HIGH][11:0])
        : in_band(lim_val[REG_PULSE_LOW][11:0], lim_val[REG_PULSE_HIGH][11:0]);
    if (ep.batt_dip && bmin != 0) t.battery_level = 10'($urandom_range(bmin - 1, 0));
    else t.battery_level = 10'($urandom_range(1023, bmin));
    t.ack_pressed = ($urandom_range(0, 99) < ep.ack_pct);
    return t;
  endfunction

  function automatic in_item_t mk(int temp, int sys, int dia, int pulse, int batt, bit ack);
    in_item_t t;
    t.temperature   = 12'(temp);
    t.systolic      = 12'(sys);
    t.diastolic     = 12'(dia);
    t.pulse_rate    = 12'(pulse);
    t.battery_level = 10'(batt);
    t.ack_pressed   = ack;
    return t;
  endfunction

  task automatic fill_ticks(int n);
    episode_t ep;
    int count;
    count = 0;
    while (count < n) begin
      ep.sys_hi    = ($urandom_range(0, 9) < 4);
      ep.dia_hi    = ($urandom_range(0, 9) < 2);
      ep.temp_out  = ($urandom_range(0, 9) < 3);
      ep.pulse_out = ($urandom_range(0, 9) < 3);
      ep.batt_dip  = ($urandom_range(0, 9) == 0);
      ep.ack_pct   = $urandom_range(0, 20);
      ep.len       = $urandom_range(1, 60);
      for (int i = 0; i < ep.len && count < n; i++) begin
        pending_ticks.push_back(make_tick(ep));
        count++;
      end
    end
  endtask

  task automatic wait_idle();
    while (pending_ticks.size() != 0 || in_ch.valid || expected_lamps.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(reg_idx_t idx, logic [15:0] value);
    logic [15:0] v;
    v = value & reg_bits(idx);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'd0, v};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    lim_val[idx] = v;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== {16'd0, v}) begin
      $error("register %0d readback: expected %0d, got %0d", idx, v, prdata);
      fail_count++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_limits(int sys, int dia, int tlo, int thi, int plo, int phi,
                            int bmin, int snooze);
    cfg_write(REG_SYS_LIMIT, 16'(sys));
    cfg_write(REG_DIA_LIMIT, 16'(dia));
    cfg_write(REG_TEMP_LOW, 16'(tlo));
    cfg_write(REG_TEMP_HIGH, 16'(thi));
    cfg_write(REG_PULSE_LOW, 16'(plo));
    cfg_write(REG_PULSE_HIGH, 16'(phi));
    cfg_write(REG_BATT_MIN, 16'(bmin));
    cfg_write(REG_SNOOZE, 16'(snooze));
  endtask

  // request driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (gap_left == 0 && idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        gap_left = $urandom_range(1, 7);
      if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (!hold_send && pending_ticks.size() != 0) begin
        in_ch.data  <= pending_ticks.pop_front();
        in_ch.valid <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result back-pressure
  always @(negedge clk) begin
    if (stall_left == 0 && idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
      stall_left = $urandom_range(1, 7);
    if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // monitor, scoreboard and watchdog
  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    bit out_taken;
    if (!rst_n) begin
      in_taken = 1'b0;
      quiet_cycles = 0;
    end else begin
      in_taken = in_ch.valid && in_ch.ready;
      out_taken = out_ch.valid && out_ch.ready;
      if (in_taken) expected_lamps.push_back(annunciate(in_ch.data));
      if (out_taken) begin
        got = out_ch.data;
        if (expected_lamps.size() == 0) begin
          $error("unexpected result %h", got);
          fail_count++;
        end else begin
          want = expected_lamps.pop_front();
          if (got.tone_on !== want.tone_on) begin
            $error("tone_on: expected %0d, got %0d", want.tone_on, got.tone_on);
            fail_count++;
          end
          if (got.red_led !== want.red_led) begin
            $error("red_led: expected %0d, got %0d", want.red_led, got.red_led);
            fail_count++;
          end
          if (got.green_led !== want.green_led) begin
            $error("green_led: expected %0d, got %0d", want.green_led, got.green_led);
            fail_count++;
          end
          if (got.yellow_led !== want.yellow_led) begin
            $error("yellow_led: expected %0d, got %0d", want.yellow_led, got.yellow_led);
            fail_count++;
          end
          if (got.remote_active !== want.remote_active) begin
            $error("remote_active: expected %0d, got %0d",
                   want.remote_active, got.remote_active);
            fail_count++;
          end
          if (got.alarm_mode !== want.alarm_mode) begin
            $error("alarm_mode: expected %0d, got %0d", want.alarm_mode, got.alarm_mode);
            fail_count++;
          end
          if (got.warning_kind !== want.warning_kind) begin
            $error("warning_kind: expected %0d, got %0d",
                   want.warning_kind, got.warning_kind);
            fail_count++;
          end
        end
      end
      if (in_taken || out_taken || psel) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("vital_sign_alarm_annunciator_core test failed");
        $finish;
      end
    end
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    fail_count = 0;
    idle_pct = 0;
    gap_left = 0;
    stall_left = 0;
    hold_send = 1'b0;
    lim_val[REG_SYS_LIMIT]  = SYS_LIMIT_RST;
    lim_val[REG_DIA_LIMIT]  = DIA_LIMIT_RST;
    lim_val[REG_TEMP_LOW]   = TEMP_LOW_RST;
    lim_val[REG_TEMP_HIGH]  = TEMP_HIGH_RST;
    lim_val[REG_PULSE_LOW]  = PULSE_LOW_RST;
    lim_val[REG_PULSE_HIGH] = PULSE_HIGH_RST;
    lim_val[REG_BATT_MIN]   = BATT_MIN_RST;
    lim_val[REG_SNOOZE]     = SNOOZE_RST;
    alarm_st = ALARM_OFF;
    warn_st = KIND_NONE;
    batt_low_st = 1'b0;
    tone_phase_st = 1'b0;
    tone_st = 1'b0;
    red_st = 1'b0;
    tick_cnt = '0;
    wake_at = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // reset limits: boundaries, each warning kind, priority, alarm and snooze
    idle_pct = 10;
    pending_ticks.push_back(mk(590, 1200, 1000, 1200, 500, 0));
    pending_ticks.push_back(mk(0, 0, 0, 0, 1023, 0));
    pending_ticks.push_back(mk(4095, 2304, 1536, 1680, 40, 0));
    pending_ticks.push_back(mk(549, 2304, 1536, 4095, 40, 0));
    pending_ticks.push_back(mk(635, 1200, 1000, 911, 600, 0));
    pending_ticks.push_back(mk(590, 1200, 1537, 1200, 600, 1));
    pending_ticks.push_back(mk(0, 2305, 4095, 0, 600, 0));
    repeat (3) pending_ticks.push_back(mk(590, 4000, 1000, 1200, 600, 0));
    pending_ticks.push_back(mk(590, 4000, 1000, 1200, 600, 1));
    pending_ticks.push_back(mk(590, 4000, 1000, 1200, 600, 0));
    pending_ticks.push_back(mk(590, 4000, 1000, 1200, 600, 1));
    pending_ticks.push_back(mk(590, 1200, 1000, 1200, 600, 0));
    pending_ticks.push_back(mk(590, 4095, 1000, 1200, 600, 0));
    pending_ticks.push_back(mk(590, 1200, 1000, 1200, 600, 0));
    pending_ticks.push_back(mk(590, 1200, 1000, 1200, 1023, 1));
    wait_idle();

    // battery threshold held at zero so green stays reachable until the battery latch test
    set_limits(2304, 1536, 549, 635, 912, 1680, 0, 25);
    idle_pct = 15;
    fill_ticks(250);
    wait_idle();

    set_limits($urandom_range(1600, 3200), $urandom_range(1000, 2200),
               $urandom_range(300, 700), $urandom_range(600, 900),
               $urandom_range(700, 1000), $urandom_range(1200, 1900),
               0, $urandom_range(1, 40));
    idle_pct = 30;
    fill_ticks(250);
    while (pending_ticks.size() > 125) @(posedge clk);
    hold_send = 1'b1;
    while (in_ch.valid || expected_lamps.size() != 0) @(posedge clk);
    hold_send = 1'b0;
    wait_idle();

    // all-zero limits, zero snooze wakes in the same tick
    set_limits(0, 0, 0, 0, 0, 0, 0, 0);
    idle_pct = 0;
    fill_ticks(150);
    wait_idle();

    set_limits(4095, 4095, 4095, 4095, 4095, 4095, 0, 65535);
    idle_pct = 20;
    fill_ticks(150);
    wait_idle();

    set_limits($urandom_range(1600, 3200), $urandom_range(1000, 2200),
               $urandom_range(500, 900), $urandom_range(300, 700),
               $urandom_range(700, 1000), $urandom_range(1200, 1900),
               0, $urandom_range(1, 8));
    idle_pct = 20;
    fill_ticks(250);
    wait_idle();

    // battery latch, then no idling to the end
    set_limits(2304, 1536, 549, 635, 912, 1680, 1023, 25);
    idle_pct = 0;
    pending_ticks.push_back(mk(590, 1200, 1000, 1200, 1023, 0));
    pending_ticks.push_back(mk(590, 1200, 1000, 1200, 0, 0));
    pending_ticks.push_back(mk(590, 1200, 1000, 1200, 1023, 0));
    fill_ticks(250);
    wait_idle();

    if (fail_count == 0) begin
      $display("vital_sign_alarm_annunciator_core test passed");
    end else begin
      $display("vital_sign_alarm_annunciator_core test failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/vsaa_pkg.sv
rtl/vsaa_if.sv
rtl/vital_sign_alarm_annunciator_core.sv
tb/tb.sv
